// ----- hw/rtl/pptr_pkg.sv -----
`timescale 1ns / 1ps
package pptr_pkg;
   localparam int PIXELS = 4096;
   localparam int ADDR_W = $clog2(PIXELS);
   localparam int COUNT_LIMIT = 65535;

   typedef enum logic [2:0] {
      MODE_MIN = 3'd0, MODE_MAX = 3'd1, MODE_SUM = 3'd2, MODE_PROD = 3'd3,
      MODE_COUNT = 3'd4, MODE_MEAN = 3'd5, MODE_VAR = 3'd6, MODE_STD = 3'd7
   } mode_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_READ, ST_MUL1, ST_DIVM, ST_MUL2, ST_WRITE,
      ST_DIV, ST_SQRT, ST_OUT
   } state_type;

   // divider control between top level and the shared unit
   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [16:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] quotient;
   } div_rsp_type;

   function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] s;
      s = a + b;
      if (!a[63] && !b[63] && s[63]) return 64'h7fff_ffff_ffff_ffff;
      if (a[63] && b[63] && !s[63]) return 64'h8000_0000_0000_0000;
      return s;
   endfunction
endpackage

// ----- hw/rtl/pptr_div.sv -----
`timescale 1ns / 1ps
// signed 64 / unsigned 17 restoring divider, one quotient bit per cycle, truncates to zero
module pptr_div
   import pptr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);
   logic [63:0] quot_ff, quot_in;
   logic [16:0] rem_ff, rem_in;
   logic [16:0] dvs_ff, dvs_in;
   logic        neg_ff, neg_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [17:0] trial;

   always_comb begin
      quot_in = quot_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      trial = '0;
      rsp.done = 1'b0;
      rsp.quotient = neg_ff ? (64'd0 - quot_ff) : quot_ff;
      if (req.start) begin
         quot_in = req.dividend[63] ? (64'd0 - req.dividend) : req.dividend;
         neg_in = req.dividend[63];
         dvs_in = req.divisor;
         rem_in = '0;
         cnt_in = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff == 7'd0) begin
            busy_in = 1'b0;
            rsp.done = 1'b1;
         end else begin
            trial = {rem_ff, quot_ff[63]};
            if (trial >= {1'b0, dvs_ff}) begin
               trial = trial - {1'b0, dvs_ff};
               quot_in = {quot_ff[62:0], 1'b1};
            end else begin
               quot_in = {quot_ff[62:0], 1'b0};
            end
            rem_in = trial[16:0];
            cnt_in = cnt_ff - 7'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end
endmodule

// ----- hw/rtl/pptr_mul.sv -----
`timescale 1ns / 1ps
// (x * y) >> 16 saturated; 64x64 magnitude product from 32x32 partials, one per cycle
module pptr_mul
   import pptr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] x,
   input  logic [63:0] y,
   output logic        done,
   output logic [63:0] prod
);
   logic [63:0]  ux_ff, uy_ff;
   logic         neg_ff;
   logic [127:0] acc_ff, acc_in;
   logic [2:0]   step_ff, step_in;
   logic [31:0]  opa, opb;
   logic [63:0]  part;
   logic [63:0]  mag, lim;

   always_comb begin
      unique case (step_ff)
         3'd1: begin opa = ux_ff[31:0]; opb = uy_ff[31:0]; end
         3'd2: begin opa = ux_ff[31:0]; opb = uy_ff[63:32]; end
         3'd3: begin opa = ux_ff[63:32]; opb = uy_ff[31:0]; end
         3'd4: begin opa = ux_ff[63:32]; opb = uy_ff[63:32]; end
         default: begin opa = '0; opb = '0; end
      endcase
      part = {32'd0, opa} * {32'd0, opb};
      acc_in = acc_ff;
      step_in = step_ff;
      case (step_ff)
         3'd1: begin acc_in = acc_ff + {64'd0, part}; step_in = 3'd2; end
         3'd2: begin acc_in = acc_ff + {32'd0, part, 32'd0}; step_in = 3'd3; end
         3'd3: begin acc_in = acc_ff + {32'd0, part, 32'd0}; step_in = 3'd4; end
         3'd4: begin acc_in = acc_ff + {part, 64'd0}; step_in = 3'd5; end
         3'd5: step_in = 3'd0;
         default: ;
      endcase
      if (start) begin
         acc_in = '0;
         step_in = 3'd1;
      end
      done = (step_ff == 3'd5);
      lim = neg_ff ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
      if (acc_ff[127:80] != '0) mag = lim;
      else if (acc_ff[79:16] > lim) mag = lim;
      else mag = acc_ff[79:16];
      prod = neg_ff ? (64'd0 - mag) : mag;
   end

   always_ff @(posedge clock) begin
      if (reset) step_ff <= '0;
      else step_ff <= step_in;
      acc_ff <= acc_in;
      if (start) begin
         ux_ff <= x[63] ? (64'd0 - x) : x;
         uy_ff <= y[63] ? (64'd0 - y) : y;
         neg_ff <= x[63] ^ y[63];
      end
   end
endmodule

// ----- hw/rtl/pptr_sqrt.sv -----
`timescale 1ns / 1ps
// floor(sqrt(v << 16)), restoring, one result bit per cycle
module pptr_sqrt
   import pptr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] value,
   output logic        done,
   output logic [63:0] root
);
   logic [79:0] rad_ff, rad_in;
   logic [41:0] rem_ff, rem_in;
   logic [39:0] res_ff, res_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [41:0] trial, cand;

   always_comb begin
      rad_in = rad_ff;
      rem_in = rem_ff;
      res_in = res_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done = 1'b0;
      trial = {rem_ff[39:0], rad_ff[79:78]};
      cand = {res_ff, 2'b01};
      if (start) begin
         rad_in = value[63] ? 80'd0 : {value, 16'd0};
         rem_in = '0;
         res_in = '0;
         cnt_in = 6'd40;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done = 1'b1;
         end else begin
            rad_in = {rad_ff[77:0], 2'b00};
            if (trial >= cand) begin
               rem_in = trial - cand;
               res_in = {res_ff[38:0], 1'b1};
            end else begin
               rem_in = trial;
               res_in = {res_ff[38:0], 1'b0};
            end
            cnt_in = cnt_ff - 6'd1;
         end
      end
      root = {24'd0, res_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      rad_ff <= rad_in;
      rem_ff <= rem_in;
      res_ff <= res_in;
   end
endmodule

// ----- hw/rtl/per_pixel_temporal_reducer.sv -----
`timescale 1ns / 1ps
// path per request: read, write-back, then for a slice end the result step; product
// adds the multiplier, mean a final divide, variance and std deviation a divide and
// a multiply per sample plus a final divide on the shared divider, std deviation then
// the bit-serial root; one request at a time: the next request is taken after the
// write-back, or once the result is handed over when one is due
// reset: mode register goes to mean, control clears; pixel memory is not cleared
module per_pixel_temporal_reducer
   import pptr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [11:0] req_pixel_index,
   input  logic signed [31:0] req_sample_value,
   input  logic        req_sample_valid,
   input  logic        req_slice_first,
   input  logic        req_slice_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [11:0] rsp_result_pixel,
   output logic signed [63:0] rsp_result_value,
   output logic        rsp_result_valid,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_aggregate_mode
);
   // per-pixel state memory: {has, mean48, count16, acc64}
   localparam int ENTRY_W = 1 + 48 + 16 + 64;
   logic [ENTRY_W-1:0] mem [PIXELS];
   logic [ENTRY_W-1:0] rd_data_ff;

   state_type state_ff, state_in;
   logic [2:0]  mode_ff;
   // captured request
   logic [11:0] pix_ff;
   logic [63:0] v_ff;
   logic        sval_ff, first_ff, last_ff;
   // working entry
   logic [63:0] acc_ff, acc_in;
   logic [47:0] mean_ff, mean_in;
   logic [15:0] cnt_ff, cnt_in;
   logic        has_ff, has_in;
   logic [63:0] delta_ff, delta_in;
   // result register
   logic        rv_ff, rv_in;
   logic [63:0] rval_ff, rval_in;
   logic        rok_ff, rok_in;

   logic        accept, mem_we;
   logic [ADDR_W-1:0] addr;
   div_req_type dreq;
   div_rsp_type drsp;
   logic        mul_start, mul_done, sq_start, sq_done;
   logic [63:0] mul_x, mul_y, mul_p, sq_root;
   logic [63:0] mean_ext;

   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE) || rv_ff;
   assign csr_ready = 1'b1;
   assign addr = pix_ff[ADDR_W-1:0];
   assign mean_ext = {{16{mean_ff[47]}}, mean_ff};

   pptr_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));
   pptr_mul u_mul (.clock(clock), .reset(reset), .start(mul_start), .x(mul_x), .y(mul_y),
                   .done(mul_done), .prod(mul_p));
   pptr_sqrt u_sqrt (.clock(clock), .reset(reset), .start(sq_start), .value(drsp.quotient),
                     .done(sq_done), .root(sq_root));

   always_comb begin
      logic [63:0] nm;
      logic        upd;
      state_in = state_ff;
      acc_in = acc_ff; mean_in = mean_ff; cnt_in = cnt_ff; has_in = has_ff;
      delta_in = delta_ff;
      rv_in = rv_ff; rval_in = rval_ff; rok_in = rok_ff;
      dreq = '0;
      mul_start = 1'b0; mul_x = acc_ff; mul_y = v_ff;
      sq_start = 1'b0;
      mem_we = 1'b0;
      nm = '0;
      upd = 1'b0;
      if (rv_ff && !rsp_stall) rv_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_READ;
         ST_READ: begin
            // memory data arrives; apply slice start clear
            if (first_ff) begin
               acc_in = '0; mean_in = '0; cnt_in = '0; has_in = 1'b0;
            end else begin
               {has_in, mean_in, cnt_in, acc_in} = rd_data_ff;
            end
            upd = sval_ff && ((first_ff ? 16'd0 : rd_data_ff[79:64]) != 16'(COUNT_LIMIT));
            state_in = ST_WRITE;
            if (upd) begin
               cnt_in = cnt_in + 16'd1;
               unique case (mode_ff)
                  MODE_MIN: if (!has_in || $signed(v_ff) < $signed(acc_in)) acc_in = v_ff;
                  MODE_MAX: if (!has_in || $signed(v_ff) > $signed(acc_in)) acc_in = v_ff;
                  MODE_SUM: acc_in = has_in ? sat_add(acc_in, v_ff) : v_ff;
                  MODE_PROD: if (has_in) state_in = ST_MUL1; else acc_in = v_ff;
                  MODE_COUNT: ;
                  MODE_MEAN: acc_in = sat_add(acc_in, v_ff);
                  default: begin
                     delta_in = v_ff - {{16{mean_in[47]}}, mean_in};
                     state_in = ST_DIVM;
                  end
               endcase
               has_in = 1'b1;
            end
            // product starts from the stored accumulator just read
            if (state_in == ST_MUL1) begin
               mul_start = 1'b1;
               mul_x = acc_in;
            end
         end
         ST_MUL1: begin
            mul_x = acc_ff;
            if (mul_done) begin acc_in = mul_p; state_in = ST_WRITE; end
         end
         ST_DIVM: begin
            dreq.start = 1'b1;
            dreq.dividend = delta_ff;
            dreq.divisor = {1'b0, cnt_ff};
            state_in = ST_MUL2;
            delta_in = delta_ff;
         end
         ST_MUL2: begin
            // phase 1: wait for delta / n, then start the multiply
            if (drsp.done) begin
               nm = mean_ext + drsp.quotient;
               mean_in = nm[47:0];
               mul_start = 1'b1;
               mul_x = delta_ff;
               mul_y = v_ff - nm;
            end
            if (mul_done) begin
               acc_in = sat_add(acc_ff, mul_p);
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            mem_we = 1'b1;
            if (!last_ff) state_in = ST_IDLE;
            else begin
               unique case (mode_ff)
                  MODE_MIN, MODE_MAX, MODE_SUM, MODE_PROD: begin
                     rok_in = has_ff; rval_in = has_ff ? acc_ff : '0; state_in = ST_OUT;
                  end
                  MODE_COUNT: begin
                     rok_in = 1'b1; rval_in = {32'd0, cnt_ff, 16'd0}; state_in = ST_OUT;
                  end
                  MODE_MEAN: begin
                     rok_in = cnt_ff != 16'd0; rval_in = '0;
                     if (cnt_ff != 16'd0) begin
                        dreq.start = 1'b1; dreq.dividend = acc_ff;
                        dreq.divisor = {1'b0, cnt_ff};
                        state_in = ST_DIV;
                     end else state_in = ST_OUT;
                  end
                  default: begin
                     rok_in = cnt_ff >= 16'd2; rval_in = '0;
                     if (cnt_ff >= 16'd2) begin
                        dreq.start = 1'b1; dreq.dividend = acc_ff;
                        dreq.divisor = {1'b0, cnt_ff - 16'd1};
                        state_in = ST_DIV;
                     end else state_in = ST_OUT;
                  end
               endcase
            end
         end
         ST_DIV: if (drsp.done) begin
            if (mode_ff == MODE_STD) begin
               sq_start = 1'b1; state_in = ST_SQRT;
            end else begin
               rval_in = drsp.quotient; state_in = ST_OUT;
            end
         end
         ST_SQRT: if (sq_done) begin rval_in = sq_root; state_in = ST_OUT; end
         ST_OUT: if (!rv_ff) begin rv_in = 1'b1; state_in = ST_IDLE; end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mode_ff <= MODE_MEAN;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff <= rv_in;
         if (csr_valid && csr_ready) mode_ff <= csr_aggregate_mode;
      end
      if (accept) begin
         pix_ff <= req_pixel_index;
         v_ff <= {{32{req_sample_value[31]}}, req_sample_value};
         sval_ff <= req_sample_valid;
         first_ff <= req_slice_first;
         last_ff <= req_slice_last;
      end
      acc_ff <= acc_in; mean_ff <= mean_in; cnt_ff <= cnt_in; has_ff <= has_in;
      delta_ff <= delta_in;
      rval_ff <= rval_in; rok_ff <= rok_in;
   end

   // state memory: one synchronous read, one write
   always_ff @(posedge clock) begin
      if (accept) rd_data_ff <= mem[req_pixel_index[ADDR_W-1:0]];
      if (mem_we) mem[addr] <= {has_ff, mean_ff, cnt_ff, acc_ff};
   end

   assign rsp_valid = rv_ff;
   assign rsp_result_pixel = pix_ff;
   assign rsp_result_value = rval_ff;
   assign rsp_result_valid = rok_ff;

   // no new request while a result waits
   assert property (@(posedge clock) disable iff (reset) rv_ff |-> !accept)
      else $error("request taken while result pending");
   // a flagged-invalid result carries zero
   assert property (@(posedge clock) disable iff (reset) (rv_ff && !rok_ff) |-> rval_ff == '0)
      else $error("nan result with nonzero value");
   // memory written only at the write step
   assert property (@(posedge clock) disable iff (reset) mem_we |-> state_ff == ST_WRITE)
      else $error("stray memory write");
endmodule

// ----- dv/per_pixel_temporal_reducer_tb.sv -----
`timescale 1ns / 1ps
module per_pixel_temporal_reducer_tb;
   import pptr_pkg::*;

   // result as seen on the response channel
   typedef struct {
      logic [11:0]        pixel;
      logic signed [63:0] value;
      logic               valid;
   } pixel_result_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [11:0] req_pixel_index;
   logic signed [31:0] req_sample_value;
   logic        req_sample_valid;
   logic        req_slice_first;
   logic        req_slice_last;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [11:0] rsp_result_pixel;
   logic signed [63:0] rsp_result_value;
   logic        rsp_result_valid;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_aggregate_mode;

   per_pixel_temporal_reducer dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_pixel_index(req_pixel_index), .req_sample_value(req_sample_value),
      .req_sample_valid(req_sample_valid), .req_slice_first(req_slice_first),
      .req_slice_last(req_slice_last),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_result_pixel(rsp_result_pixel), .rsp_result_value(rsp_result_value),
      .rsp_result_valid(rsp_result_valid),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_aggregate_mode(csr_aggregate_mode)
   );

   // worst-case drain time after the last result (std deviation path)
   localparam int DRAIN_CYCLES = 300;

   // mirror of the block's per-pixel state and mode register
   mode_type    shadow_mode;
   longint      acc_mem [PIXELS];
   int          count_mem [PIXELS];
   longint      mean_mem [PIXELS];
   bit          seen_mem [PIXELS];
   bit          touched [PIXELS];   // entry cleared at least once, safe to read

   pixel_result_type pending_results [$];
   int          error_count;
   int          send_idle_pct;
   int          recv_idle_pct;

   // clock generation
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // saturating 64-bit add
   function automatic longint sat_add64(input longint a, input longint b);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      if (s > 65'sh0_7fff_ffff_ffff_ffff) return 64'sh7fff_ffff_ffff_ffff;
      if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
      return longint'(s[63:0]);
   endfunction

   // (x * y) >> 16 with magnitude truncation and saturation
   function automatic longint q16_mul(input longint x, input longint y);
      logic [63:0]  ux, uy, mag, lim;
      logic [127:0] p;
      bit           neg;
      ux  = (x < 0) ? -x : x;
      uy  = (y < 0) ? -y : y;
      neg = (x < 0) != (y < 0);
      p   = {64'd0, ux} * {64'd0, uy};
      lim = neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
      if (p[127:80] != 0) mag = lim;
      else begin
         mag = p[79:16];
         if (mag > lim) mag = lim;
      end
      return neg ? longint'(-mag) : longint'(mag);
   endfunction

   // floor(sqrt(v * 2^16)), non-positive gives 0
   function automatic longint q16_sqrt(input longint v);
      logic [127:0] target, sq;
      logic [63:0]  r, c;
      if (v <= 0) return 0;
      target = {64'd0, v} << 16;
      r = 0;
      for (int b = 39; b >= 0; b--) begin
         c  = r | (64'd1 << b);
         sq = {64'd0, c} * {64'd0, c};
         if (sq <= target) r = c;
      end
      return longint'(r);
   endfunction

   // update mirror state for one request; returns 1 if a result is due
   function automatic bit reduce_sample(input logic [11:0] pix, input logic signed [31:0] sv,
                                        input bit present, input bit first, input bit last,
                                        output pixel_result_type res);
      longint v, acc, m, d, val;
      int     n;
      bit     ok;
      v = sv;
      if (first) begin
         acc_mem[pix] = 0; count_mem[pix] = 0; mean_mem[pix] = 0; seen_mem[pix] = 0;
      end
      if (present && count_mem[pix] < COUNT_LIMIT) begin
         acc = acc_mem[pix];
         n = count_mem[pix] + 1;
         case (shadow_mode)
            MODE_MIN:   acc = (!seen_mem[pix] || v < acc) ? v : acc;
            MODE_MAX:   acc = (!seen_mem[pix] || v > acc) ? v : acc;
            MODE_SUM:   acc = seen_mem[pix] ? sat_add64(acc, v) : v;
            MODE_PROD:  acc = seen_mem[pix] ? q16_mul(acc, v) : v;
            MODE_COUNT: ;
            MODE_MEAN:  acc = sat_add64(acc, v);
            default: begin
               // welford online update
               m = mean_mem[pix];
               d = v - m;
               m = m + d / longint'(n);
               mean_mem[pix] = m;
               acc = sat_add64(acc, q16_mul(d, v - m));
            end
         endcase
         acc_mem[pix] = acc;
         count_mem[pix] = n;
         seen_mem[pix] = 1;
      end
      if (!last) return 0;
      n = count_mem[pix];
      val = 0;
      case (shadow_mode)
         MODE_MIN, MODE_MAX, MODE_SUM, MODE_PROD: begin
            ok = seen_mem[pix];
            val = acc_mem[pix];
         end
         MODE_COUNT: begin
            ok = 1;
            val = longint'(n) * 65536;
         end
         MODE_MEAN: begin
            ok = n >= 1;
            if (ok) val = acc_mem[pix] / longint'(n);
         end
         MODE_VAR: begin
            ok = n >= 2;
            if (ok) val = acc_mem[pix] / longint'(n - 1);
         end
         default: begin
            ok = n >= 2;
            if (ok) val = q16_sqrt(acc_mem[pix] / longint'(n - 1));
         end
      endcase
      res.pixel = pix;
      res.value = ok ? val : 64'sd0;
      res.valid = ok;
      return 1;
   endfunction

   // one request on the input channel; valid stays high into the next request unless an idle gap is drawn
   task automatic send_sample(input logic [11:0] pix, input logic signed [31:0] sv,
                              input bit present, input bit first, input bit last);
      pixel_result_type res;
      int gap;
      if ($urandom_range(99) < send_idle_pct) begin
         gap = $urandom_range(4, 1);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_pixel_index  <= pix;
      req_sample_value <= sv;
      req_sample_valid <= present;
      req_slice_first  <= first;
      req_slice_last   <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      touched[pix] = touched[pix] | first;
      if (reduce_sample(pix, sv, present, first, last, res))
         pending_results = {pending_results, res};
   endtask

   // stop sending and let every expected result come home
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // mode register write, only called with the block idle
   task automatic write_mode(input mode_type m);
      csr_aggregate_mode <= m;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      shadow_mode = m;
   endtask

   function automatic logic signed [31:0] pick_sample();
      case ($urandom_range(4))
         0: return $urandom;
         1: return $signed($urandom_range(32'h3_ffff)) - 32'sh2_0000;
         2: return 32'sh1_0000 + $signed($urandom_range(32'h1fff)) - 32'sh1000;
         3: return $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
         default: return $signed($urandom_range(32'hff_ffff)) - 32'sh80_0000;
      endcase
   endfunction

   // extremes of the sample range and an empty slice under every mode
   task automatic test_directed_extremes();
      for (int i = 0; i < 8; i++) begin
         write_mode(mode_type'(i));
         send_sample(12'd0, 32'sh7fff_ffff, 1'b1, 1'b1, 1'b0);
         send_sample(12'd0, 32'sh8000_0000, 1'b1, 1'b0, 1'b1);
         // slice with only a missing sample
         send_sample(12'hfff, 32'sh0001_0000, 1'b0, 1'b1, 1'b1);
         drain_results();
      end
   endtask

   // random slices on a small pool of pixels, so slices overlap and span mode changes
   task automatic test_random_slices(input int items, input bit hold_off);
      logic [11:0] pool [6];
      logic [11:0] pix;
      bit first;
      for (int k = 0; k < 6; k++) pool[k] = 12'($urandom_range(4095));
      pool[0] = $urandom_range(1) ? 12'd0 : 12'hfff;
      for (int k = 0; k < items; k++) begin
         pix = pool[$urandom_range(5)];
         // never read an entry that was not cleared yet
         first = !touched[pix] || ($urandom_range(7) == 0);
         send_sample(pix, pick_sample(), $urandom_range(99) < 85, first,
                     $urandom_range(3) == 0);
         if (hold_off && k == items / 2) begin
            req_valid <= 1'b0;
            while (pending_results.size() != 0) @(posedge clock);
         end
      end
      drain_results();
   endtask

   // receiver stall pattern
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // compare each handed-over result with the oldest prediction
   always @(posedge clock) begin
      pixel_result_type exp_res;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result pixel %0d value %0d valid %0d", $time,
                     rsp_result_pixel, rsp_result_value, rsp_result_valid);
            error_count++;
         end else begin
            exp_res = pending_results.pop_front();
            if (rsp_result_pixel !== exp_res.pixel) begin
               $display("%0t: pixel expected %0d actual %0d", $time, exp_res.pixel,
                        rsp_result_pixel);
               error_count++;
            end
            if (rsp_result_value !== exp_res.value) begin
               $display("%0t: value expected %0d actual %0d", $time, exp_res.value,
                        rsp_result_value);
               error_count++;
            end
            if (rsp_result_valid !== exp_res.valid) begin
               $display("%0t: valid expected %0d actual %0d", $time, exp_res.valid,
                        rsp_result_valid);
               error_count++;
            end
         end
      end
   end

   // hard limit on run time
   initial begin
      #20ms;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_pixel_index    <= '0;
      req_sample_value   <= '0;
      req_sample_valid   <= 1'b0;
      req_slice_first    <= 1'b0;
      req_slice_last     <= 1'b0;
      csr_valid          <= 1'b0;
      csr_aggregate_mode <= '0;
      error_count   = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      shadow_mode   = MODE_MEAN;
      for (int k = 0; k < PIXELS; k++) touched[k] = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_extremes();

      // three idle settings, each sweeping every mode
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 13 : (ph == 1) ? 53 : 0;
         recv_idle_pct = (ph == 0) ? 53 : (ph == 1) ? 13 : 0;
         for (int i = 0; i < 8; i++) begin
            write_mode(mode_type'((i + 3 * ph) % 8));
            test_random_slices(58, ph == 0 && i == 0);
         end
      end

      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
